### sv/kssk_pkg.sv
package kssk_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int KEY_ENTRIES_DEF = 104;
    localparam int TIME_BITS_DEF   = 32;

    // Fixed field widths.
    localparam int CODE_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int GAP_W     = 16;
    localparam int STIME_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int BITCNT_W  = 3;
    localparam int KSTATE_W  = 2;

    // Register reset values.
    localparam logic [GAP_W-1:0]  GAP_LIMIT_RST   = 16'd1000;
    localparam logic [CODE_W-1:0] CTRL_CODE_RST   = 7'd99;
    localparam logic [CODE_W-1:0] ALT_CODE_RST    = 7'd100;
    localparam logic [CODE_W-1:0] TOGGLE_CODE_RST = 7'd68;

    // Decoded byte that wipes the whole keymap.
    localparam logic [BYTE_W-1:0] CLEAR_BYTE = 8'hFD;

    // Item operation codes.
    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_LIMIT  = 2'd0,
        CFG_CTRL_KEY   = 2'd1,
        CFG_ALT_KEY    = 2'd2,
        CFG_TOGGLE_KEY = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RD_CTRL,
        ST_RD_ALT,
        ST_RD_KEY,
        ST_FINISH
    } ctl_state_t;

    typedef enum logic [1:0] {
        RD_SEL_CTRL,
        RD_SEL_ALT,
        RD_SEL_KEY
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    eval;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_ctrl;
        logic    cap_alt;
        logic    finish;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_map;
    } dp_status_t;

endpackage

### sv/kssk_ram.sv
module kssk_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 104
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/kssk_ctrl.sv
module kssk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  kssk_pkg::dp_status_t status,
    output kssk_pkg::ctl_cmd_t  cmd,
    output logic                busy
);

    import kssk_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_sel   = RD_SEL_KEY;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.need_map ? ST_RD_CTRL : ST_FINISH;
            end
            ST_RD_CTRL:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SEL_CTRL;
                state_next = ST_RD_ALT;
            end
            ST_RD_ALT:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_SEL_ALT;
                cmd.cap_ctrl = 1'b1;
                state_next   = ST_RD_KEY;
            end
            ST_RD_KEY:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_SEL_KEY;
                cmd.cap_alt = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### sv/kssk_datapath.sv
module kssk_datapath #(
    parameter int KEY_ENTRIES = kssk_pkg::KEY_ENTRIES_DEF,
    parameter int TIME_BITS   = kssk_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kssk_pkg::ctl_cmd_t              cmd,
    output kssk_pkg::dp_status_t            status,
    // Configuration write channel.
    input  logic                            cfg_valid,
    input  logic [kssk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kssk_pkg::CFG_DAT_W-1:0]  cfg_data,
    // Item fields.
    input  logic                            op,
    input  logic                            data_bit,
    input  logic [kssk_pkg::STIME_W-1:0]    time_us,
    input  logic [kssk_pkg::CODE_W-1:0]     key_index,
    // Keymap storage port.
    output logic                            km_we,
    output logic [$clog2(KEY_ENTRIES)-1:0]  km_waddr,
    output logic [kssk_pkg::KSTATE_W-1:0]   km_wdata,
    output logic [$clog2(KEY_ENTRIES)-1:0]  km_raddr,
    input  logic [kssk_pkg::KSTATE_W-1:0]   km_rdata,
    // Result.
    output logic                            done,
    output logic                            byte_valid,
    output logic [kssk_pkg::BYTE_W-1:0]     key_byte,
    output logic                            ack_request,
    output logic                            force_release,
    output logic                            pressed,
    output logic                            overlay_held_out
);

    import kssk_pkg::*;

    localparam int AW = $clog2(KEY_ENTRIES);
    localparam logic [CODE_W:0] ENTRIES_LIM = (CODE_W+1)'(KEY_ENTRIES);

    // Configuration registers.
    logic [GAP_W-1:0]  gap_limit_reg;
    logic [CODE_W-1:0] ctrl_code_reg;
    logic [CODE_W-1:0] alt_code_reg;
    logic [CODE_W-1:0] toggle_code_reg;

    // Captured item.
    logic                 op_reg;
    logic                 bit_in_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [CODE_W-1:0]    kidx_reg;

    // Line state.
    logic [BITCNT_W-1:0]  bit_count_reg;
    logic [BYTE_W-1:0]    shift_byte_reg;
    logic [TIME_BITS-1:0] last_time_reg;
    logic                 resync_reg;
    logic                 overlay_reg;
    logic [KEY_ENTRIES-1:0] key_vld_reg;

    // Results of the evaluation step.
    logic              full_reg;
    logic              ack_reg;
    logic [CODE_W-1:0] key_addr_reg;
    logic              key_ok_reg;

    // Keymap read results.
    logic rd_ok_reg;
    logic ctrl_held_reg;
    logic alt_held_reg;

    // Result registers.
    logic              done_reg;
    logic              byte_valid_reg;
    logic [BYTE_W-1:0] key_byte_reg;
    logic              ack_out_reg;
    logic              force_reg;
    logic              pressed_reg;

    // Evaluation logic.
    logic [TIME_BITS-1:0] diff;
    logic                 gap;
    logic                 dropped;
    logic [BITCNT_W-1:0]  bit_count_next;
    logic [BYTE_W-1:0]    shift_byte_next;
    logic                 full_next;
    logic [CODE_W-1:0]    code_next;
    logic [CODE_W-1:0]    key_addr_next;

    // Read and finish logic.
    logic [CODE_W-1:0]   rd_code;
    logic                rd_ok_next;
    logic                held_now;
    logic [KSTATE_W-1:0] st;
    logic                mods;
    logic                gate;
    logic [BYTE_W-1:0]   kbyte;
    logic                is_press;
    logic                toggle_hit;
    logic                wipe;

    always_comb
    begin
        diff            = time_reg - last_time_reg;
        gap             = !diff[TIME_BITS-1] && (diff > TIME_BITS'(gap_limit_reg))
                          && (bit_count_reg != '0);
        dropped         = gap && resync_reg;
        bit_count_next  = gap ? BITCNT_W'(!dropped) : (bit_count_reg + 1'b1);
        shift_byte_next = {shift_byte_reg[BYTE_W-2:0], bit_in_reg};
        full_next       = !dropped && (bit_count_next == '0) && (op_reg == OP_EDGE);
        code_next       = ~shift_byte_next[BYTE_W-1:1];
        key_addr_next   = (op_reg == OP_QUERY) ? kidx_reg : code_next;
    end

    assign status.need_map = (op_reg == OP_QUERY) || full_next;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_SEL_CTRL: rd_code = ctrl_code_reg;
            RD_SEL_ALT:  rd_code = alt_code_reg;
            RD_SEL_KEY:  rd_code = key_addr_reg;
            default:     rd_code = key_addr_reg;
        endcase
        rd_ok_next = ({1'b0, rd_code} < ENTRIES_LIM) && key_vld_reg[rd_code[AW-1:0]];
    end

    assign km_raddr = rd_code[AW-1:0];

    always_comb
    begin
        held_now   = rd_ok_reg && km_rdata[0];
        st         = rd_ok_reg ? km_rdata : '0;
        mods       = ctrl_held_reg && alt_held_reg;
        gate       = mods || overlay_reg;
        is_press   = bit_in_reg;
        kbyte      = {~bit_in_reg, key_addr_reg};
        toggle_hit = full_reg && key_ok_reg && is_press
                     && (key_addr_reg == toggle_code_reg) && mods;
        wipe       = full_reg && (kbyte == CLEAR_BYTE);
        km_we      = cmd.finish && key_ok_reg && (full_reg || (op_reg == OP_QUERY));
        km_waddr   = key_addr_reg[AW-1:0];
        if (op_reg == OP_QUERY)
        begin
            km_wdata = {1'b0, st[0]};
        end
        else if (is_press)
        begin
            km_wdata = 2'b11;
        end
        else
        begin
            km_wdata = {st[1], 1'b0};
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg   <= GAP_LIMIT_RST;
            ctrl_code_reg   <= CTRL_CODE_RST;
            alt_code_reg    <= ALT_CODE_RST;
            toggle_code_reg <= TOGGLE_CODE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAP_LIMIT:  gap_limit_reg   <= cfg_data;
                CFG_CTRL_KEY:   ctrl_code_reg   <= cfg_data[CODE_W-1:0];
                CFG_ALT_KEY:    alt_code_reg    <= cfg_data[CODE_W-1:0];
                CFG_TOGGLE_KEY: toggle_code_reg <= cfg_data[CODE_W-1:0];
                default:        gap_limit_reg   <= gap_limit_reg;
            endcase
        end
    end

    // Item capture and scratch registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            bit_in_reg <= data_bit;
            time_reg   <= TIME_BITS'(time_us);
            kidx_reg   <= key_index;
        end
        if (cmd.eval)
        begin
            full_reg     <= full_next;
            ack_reg      <= (op_reg == OP_EDGE) && (dropped || full_next);
            key_addr_reg <= key_addr_next;
            key_ok_reg   <= ({1'b0, key_addr_next} < ENTRIES_LIM);
        end
        if (cmd.rd_en)
        begin
            rd_ok_reg <= rd_ok_next;
        end
        if (cmd.cap_ctrl)
        begin
            ctrl_held_reg <= held_now;
        end
        if (cmd.cap_alt)
        begin
            alt_held_reg <= held_now;
        end
        if (cmd.finish)
        begin
            byte_valid_reg <= full_reg;
            key_byte_reg   <= full_reg ? kbyte : '0;
            ack_out_reg    <= ack_reg;
            force_reg      <= full_reg && is_press && gate;
            pressed_reg    <= (op_reg == OP_QUERY) && key_ok_reg && gate && (st != '0);
        end
    end

    // Line state and keymap valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= '0;
            shift_byte_reg <= '0;
            last_time_reg  <= '0;
            resync_reg     <= 1'b0;
            overlay_reg    <= 1'b0;
            key_vld_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.eval && (op_reg == OP_EDGE))
            begin
                resync_reg    <= gap;
                bit_count_reg <= bit_count_next;
                if (!dropped)
                begin
                    last_time_reg  <= time_reg;
                    shift_byte_reg <= shift_byte_next;
                end
            end
            if (cmd.finish)
            begin
                if (toggle_hit)
                begin
                    overlay_reg <= !overlay_reg;
                end
                if (wipe)
                begin
                    key_vld_reg <= '0;
                end
                else if (km_we)
                begin
                    key_vld_reg[key_addr_reg[AW-1:0]] <= 1'b1;
                end
            end
        end
    end

    assign done             = done_reg;
    assign byte_valid       = byte_valid_reg;
    assign key_byte         = key_byte_reg;
    assign ack_request      = ack_out_reg;
    assign force_release    = force_reg;
    assign pressed          = pressed_reg;
    assign overlay_held_out = overlay_reg;

endmodule

### sv/keyboard_serial_sniffer_keymap_unit.sv
// Keyboard serial-line sniffer with a keymap. Each item is either one falling
// edge of the keyboard clock (op low: data_bit and its time_us stamp) or a
// key query (op high: key_index). An item is taken at a clock edge where start
// is high and busy is low, and exactly one result comes back on the result
// ports for a single cycle, marked by done; the receiver cannot stall, so it
// must take every result beat in the cycle it is shown. An edge that does not
// complete a byte goes through the evaluation and finish steps only. The
// block takes no new item while busy, and busy falls in the cycle that shows
// the result of the last item. An edge that completes a byte, and every query,
// also reads the keymap three times through its single read port (the two
// modifier keys, then the key itself) and then writes the key's entry if the
// key lies within the keymap. The keymap lives in a RAM with a valid flip-flop
// per key, so both reset and the keymap clear byte wipe it by clearing those
// flip-flops, with no clearing pass.
// Configuration writes on the cfg channel are always ready and must only be
// issued while the block is idle.
module keyboard_serial_sniffer_keymap_unit #(
    parameter int KEY_ENTRIES = kssk_pkg::KEY_ENTRIES_DEF,
    parameter int TIME_BITS   = kssk_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Item channel.
    input  logic                            start,
    output logic                            busy,
    input  logic                            op,
    input  logic                            data_bit,
    input  logic [kssk_pkg::STIME_W-1:0]    time_us,
    input  logic [kssk_pkg::CODE_W-1:0]     key_index,
    // Configuration channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kssk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kssk_pkg::CFG_DAT_W-1:0]  cfg_data,
    // Result channel.
    output logic                            done,
    output logic                            byte_valid,
    output logic [kssk_pkg::BYTE_W-1:0]     key_byte,
    output logic                            ack_request,
    output logic                            force_release,
    output logic                            pressed,
    output logic                            overlay_held_out
);

    import kssk_pkg::*;

    localparam int AW = $clog2(KEY_ENTRIES);

    ctl_cmd_t   cmd;
    dp_status_t status;

    logic                km_we;
    logic [AW-1:0]       km_waddr;
    logic [KSTATE_W-1:0] km_wdata;
    logic [AW-1:0]       km_raddr;
    logic [KSTATE_W-1:0] km_rdata;

    // Register writes always complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    // The controller sequences evaluation, keymap reads and the final update.
    kssk_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // The datapath holds the line state, the configuration and the result.
    kssk_datapath #(
        .KEY_ENTRIES (KEY_ENTRIES),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .op               (op),
        .data_bit         (data_bit),
        .time_us          (time_us),
        .key_index        (key_index),
        .km_we            (km_we),
        .km_waddr         (km_waddr),
        .km_wdata         (km_wdata),
        .km_raddr         (km_raddr),
        .km_rdata         (km_rdata),
        .done             (done),
        .byte_valid       (byte_valid),
        .key_byte         (key_byte),
        .ack_request      (ack_request),
        .force_release    (force_release),
        .pressed          (pressed),
        .overlay_held_out (overlay_held_out)
    );

    // Two bits per key: bit 0 is held, bit 1 is sticky until queried.
    kssk_ram #(
        .WIDTH (KSTATE_W),
        .DEPTH (KEY_ENTRIES)
    ) u_keymap (
        .clk   (clk),
        .we    (km_we),
        .waddr (km_waddr),
        .wdata (km_wdata),
        .raddr (km_raddr),
        .rdata (km_rdata)
    );

`ifndef SYNTHESIS
    // A result beat always closes an item that was in flight.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without an item in flight");

    // A taken item keeps the block busy on the next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    // Every decoded byte asks for the handshake pulse.
    a_byte_acks: assert property (@(posedge clk) disable iff (!rst_n)
        (done && byte_valid) |-> ack_request)
        else $error("decoded byte without handshake request");

    // A forced release only ever accompanies a decoded press.
    a_force_on_press: assert property (@(posedge clk) disable iff (!rst_n)
        (done && force_release) |-> (byte_valid && !key_byte[7]))
        else $error("force release outside a decoded press");

    // A query answer never comes with a decoded byte.
    a_pressed_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pressed) |-> (!byte_valid && !ack_request))
        else $error("query answer mixed with edge result");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

// Testbench for the keyboard serial sniffer with keymap.
//
// Items go in over the start/busy command channel, one beat per item, and each
// item returns exactly one result beat marked by done. The receiver cannot
// stall, so every result is sampled on the falling clock edge of the cycle it
// is shown in. Inputs are driven with nonblocking assignments at the rising
// edge, and acceptance is judged from busy as seen at the falling edge before
// it. That way no decision depends on the order of events within a time step.
//
// A behavioral copy of the block runs alongside the stimulus. It keeps its own
// bit counter, partial byte, last edge stamp, resync flag, overlay hold flag,
// keymap and register shadows. When an item is taken, it computes the result
// that item must produce and queues it. The checker pops the oldest entry for
// each result beat and compares it field by field.
module testbench;
    import kssk_pkg::*;

    localparam int KEYS = KEY_ENTRIES_DEF;

    // One result beat as the block presents it.
    typedef struct packed {
        logic             byte_valid;
        logic [BYTE_W-1:0] key_byte;
        logic             ack;
        logic             force_rel;
        logic             pressed;
        logic             overlay;
    } line_result_t;

    // Decoded byte code that carries the keymap clear byte when released.
    localparam logic [CODE_W-1:0] CLEAR_CODE = CLEAR_BYTE[CODE_W-1:0];

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    logic                 op        = OP_EDGE;
    logic                 data_bit  = 1'b0;
    logic [STIME_W-1:0]   time_us   = '0;
    logic [CODE_W-1:0]    key_index = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_GAP_LIMIT;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 done;
    logic                 byte_valid;
    logic [BYTE_W-1:0]    key_byte;
    logic                 ack_request;
    logic                 force_release;
    logic                 pressed;
    logic                 overlay_held_out;

    keyboard_serial_sniffer_keymap_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .data_bit         (data_bit),
        .time_us          (time_us),
        .key_index        (key_index),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .byte_valid       (byte_valid),
        .key_byte         (key_byte),
        .ack_request      (ack_request),
        .force_release    (force_release),
        .pressed          (pressed),
        .overlay_held_out (overlay_held_out)
    );

    // Register shadows, loaded with the reset values of the block.
    logic [GAP_W-1:0]  cfg_gap    = GAP_LIMIT_RST;
    logic [CODE_W-1:0] cfg_ctrl   = CTRL_CODE_RST;
    logic [CODE_W-1:0] cfg_alt    = ALT_CODE_RST;
    logic [CODE_W-1:0] cfg_toggle = TOGGLE_CODE_RST;

    // Line and keymap state as the block should hold it.
    logic [BITCNT_W-1:0] bits_in_byte    = '0;
    logic [BYTE_W-1:0]   partial_byte    = '0;
    logic [STIME_W-1:0]  last_stamp      = '0;
    logic                resync_pending  = 1'b0;
    logic                overlay_latched = 1'b0;
    logic [KSTATE_W-1:0] key_map [KEYS];

    // Results owed by the block, oldest first.
    line_result_t awaited_results [$];
    line_result_t head;

    // Free-running microsecond clock of the keyboard line; wraps at 2^32.
    logic [STIME_W-1:0] now_us = '0;
    logic [CODE_W-1:0]  last_code = '0;
    int idle_pct = 0;

    int mismatch_count = 0;
    int items_sent     = 0;
    int queries_sent   = 0;
    int bytes_decoded  = 0;
    int edges_dropped  = 0;
    int overlay_flips  = 0;
    int settings_used  = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #3_000_000;
        $display("Timed out with %0d results still owed.", awaited_results.size());
        $display("testbench failed");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        $display("%0t ns: MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    function automatic logic key_held(input logic [CODE_W-1:0] code);
        if (code >= KEYS)
            return 1'b0;
        return key_map[code][0];
    endfunction

    function automatic logic modifiers_down();
        return key_held(cfg_ctrl) && key_held(cfg_alt);
    endfunction

    // Applies one accepted item to the shadow state and returns the result
    // beat that the block owes for it.
    function automatic line_result_t track_keyboard(input logic op_v, input logic bit_v,
                                                    input logic [STIME_W-1:0] stamp,
                                                    input logic [CODE_W-1:0] key);
        line_result_t r;
        logic [STIME_W-1:0]  delta;
        logic [KSTATE_W-1:0] prior;
        logic [CODE_W-1:0]   code;
        logic                dropped;
        r = '0;
        dropped = 1'b0;
        if (op_v == OP_QUERY)
        begin
            if (key < KEYS)
            begin
                prior = key_map[key];
                key_map[key] = prior & 2'b01;
                r.pressed = (modifiers_down() || overlay_latched) && (prior != 2'b00);
            end
        end
        else
        begin
            // The stamp difference is read as signed; only a forward jump past
            // the limit in the middle of a byte counts as a gap.
            delta = stamp - last_stamp;
            if (!delta[STIME_W-1] && delta > STIME_W'(cfg_gap) && bits_in_byte != 0)
            begin
                bits_in_byte = '0;
                if (resync_pending)
                begin
                    r.ack = 1'b1;
                    dropped = 1'b1;
                    edges_dropped++;
                end
                else
                begin
                    resync_pending = 1'b1;
                end
            end
            else
            begin
                resync_pending = 1'b0;
            end
            if (!dropped)
            begin
                last_stamp = stamp;
                bits_in_byte = bits_in_byte + 1'b1;
                partial_byte = {partial_byte[BYTE_W-2:0], bit_v};
                if (bits_in_byte == 0)
                begin
                    code = ~partial_byte[BYTE_W-1:1];
                    r.force_rel = bit_v && (modifiers_down() || overlay_latched);
                    if (code < KEYS)
                    begin
                        if (bit_v)
                        begin
                            if (code == cfg_toggle && modifiers_down())
                            begin
                                overlay_latched = !overlay_latched;
                                overlay_flips++;
                            end
                            key_map[code] = 2'b11;
                        end
                        else
                        begin
                            key_map[code] = key_map[code] & 2'b10;
                        end
                    end
                    r.key_byte = {~bit_v, code};
                    if (r.key_byte == CLEAR_BYTE)
                        foreach (key_map[i])
                            key_map[i] = 2'b00;
                    r.byte_valid = 1'b1;
                    r.ack = 1'b1;
                    bytes_decoded++;
                end
            end
        end
        r.overlay = overlay_latched;
        return r;
    endfunction

    // Sends one item beat. Called right after a rising edge; it returns right
    // after the edge that took the beat, leaving start high so that the next
    // item can follow at once. Whoever pauses the stream lowers start.
    task automatic send_item(input logic op_v, input logic bit_v,
                             input logic [STIME_W-1:0] stamp, input logic [CODE_W-1:0] key);
        logic took;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        start     <= 1'b1;
        op        <= op_v;
        data_bit  <= bit_v;
        time_us   <= stamp;
        key_index <= key;
        do
        begin
            @(negedge clk);
            took = (busy === 1'b0);
            @(posedge clk);
        end while (!took);
        awaited_results.push_back(track_keyboard(op_v, bit_v, stamp, key));
        items_sent++;
        if (op_v == OP_QUERY)
            queries_sent++;
    endtask

    task automatic send_edge(input logic bit_v, input logic [STIME_W-1:0] step_us);
        now_us = now_us + step_us;
        send_item(OP_EDGE, bit_v, now_us, CODE_W'($urandom_range(0, 127)));
    endtask

    task automatic send_query(input logic [CODE_W-1:0] key);
        send_item(OP_QUERY, 1'($urandom_range(0, 1)), $urandom, key);
    endtask

    // Step that stays within the gap limit, and one that exceeds it.
    function automatic logic [STIME_W-1:0] quiet_step();
        return $urandom_range(0, cfg_gap);
    endfunction

    function automatic logic [STIME_W-1:0] gap_step();
        return STIME_W'(cfg_gap) + 1 + $urandom_range(0, 20000);
    endfunction

    // Sends the edges of one key byte, most significant bit first. If the
    // line is in the middle of a byte, it is brought back in step first, either
    // by a gap before the first bit or by filler edges.
    task automatic send_key_byte(input logic [CODE_W-1:0] code, input logic press);
        logic [BYTE_W-1:0] frame;
        int first;
        int i;
        frame = {~code, press};
        first = 0;
        if (bits_in_byte != 0 && $urandom_range(0, 1) == 1)
        begin
            send_edge(frame[BYTE_W-1], gap_step());
            if (bits_in_byte == 1)
                first = 1;
        end
        if (first == 0)
            while (bits_in_byte != 0)
                send_edge(1'($urandom_range(0, 1)), quiet_step());
        for (i = first; i < BYTE_W; i++)
            send_edge(frame[BYTE_W-1-i], quiet_step());
        last_code = code;
    endtask

    // Waits until every owed result has come back, then lets the pipeline
    // settle before any register is touched.
    task automatic wait_for_quiet();
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes one register beat; cfg_valid is left high for a following write.
    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            took = (cfg_ready === 1'b1);
            @(posedge clk);
        end while (!took);
        case (idx)
            CFG_GAP_LIMIT:  cfg_gap    = value;
            CFG_CTRL_KEY:   cfg_ctrl   = value[CODE_W-1:0];
            CFG_ALT_KEY:    cfg_alt    = value[CODE_W-1:0];
            CFG_TOGGLE_KEY: cfg_toggle = value[CODE_W-1:0];
            default: ;
        endcase
    endtask

    // Code registers get random junk above bit 6, which the block must drop.
    task automatic program_registers(input logic [GAP_W-1:0] gap, input logic [CODE_W-1:0] ctrl,
                                     input logic [CODE_W-1:0] alt, input logic [CODE_W-1:0] tog);
        wait_for_quiet();
        write_register(CFG_GAP_LIMIT, gap);
        write_register(CFG_CTRL_KEY, {9'($urandom_range(0, 511)), ctrl});
        write_register(CFG_ALT_KEY, {9'($urandom_range(0, 511)), alt});
        write_register(CFG_TOGGLE_KEY, {9'($urandom_range(0, 511)), tog});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return cfg_ctrl;
        if (r < 24) return cfg_alt;
        if (r < 34) return cfg_toggle;
        if (r < 37) return CLEAR_CODE;
        if (r < 45) return CODE_W'($urandom_range(KEYS, 127));
        return CODE_W'($urandom_range(0, KEYS - 1));
    endfunction

    function automatic logic [CODE_W-1:0] pick_query_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return cfg_ctrl;
        if (r < 20) return cfg_alt;
        if (r < 30) return cfg_toggle;
        if (r < 55) return last_code;
        return CODE_W'($urandom_range(0, 127));
    endfunction

    // Mostly well-formed key bytes and queries, with line noise, stamp jumps
    // and back-to-back gaps mixed in. Idling comes and goes in stretches.
    task automatic random_traffic(input int n_items, input int idle_max);
        int goal;
        int pick;
        int n;
        goal = items_sent + n_items;
        idle_pct = 0;
        while (items_sent < goal)
        begin
            if (idle_max != 0 && $urandom_range(0, 29) == 0)
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, idle_max);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                send_key_byte(pick_code(), $urandom_range(0, 9) < 6);
            end
            else if (pick < 75)
            begin
                send_query(pick_query_key());
            end
            else if (pick < 88)
            begin
                n = $urandom_range(1, 7);
                repeat (n)
                    send_edge(1'($urandom_range(0, 1)),
                              ($urandom_range(0, 3) == 0) ? gap_step() : quiet_step());
            end
            else if (pick < 95)
            begin
                case ($urandom_range(0, 3))
                    0: send_edge(1'($urandom_range(0, 1)), -$urandom_range(1, 1 << 20));
                    1: send_edge(1'($urandom_range(0, 1)), 32'h8000_0000);
                    2: send_edge(1'($urandom_range(0, 1)), 32'h7FFF_FFFF);
                    default: send_edge(1'($urandom_range(0, 1)), $urandom);
                endcase
            end
            else
            begin
                // A gap followed at once by another gap: the second gap edge must be dropped.
                if (bits_in_byte == 0)
                    send_edge(1'($urandom_range(0, 1)), quiet_step());
                send_edge(1'($urandom_range(0, 1)), gap_step());
                send_edge(1'($urandom_range(0, 1)), gap_step());
            end
        end
    endtask

    // Walks each special case once with the reset register values.
    task automatic test_directed_cases();
        idle_pct = 0;
        send_query(7'd0);
        send_query(7'd127);             // beyond the keymap, answers not pressed
        send_key_byte(7'd0, 1'b1);      // press of the lowest code, all-ones frame
        send_edge(1'b1, 32'd5);
        send_edge(1'b0, gap_step());    // first gap arms the resync
        send_edge(1'b1, gap_step());    // second gap in a row is dropped
        send_edge(1'b0, -32'd5000);     // stamp going backward is no gap
        send_edge(1'b1, 32'h8000_0000); // exactly half the range reads negative
        send_edge(1'b0, 32'h7FFF_FFFF); // largest forward jump is a gap
        send_query(7'd0);               // sticky bit is read and cleared
        send_query(7'(KEYS - 1));
        send_key_byte(CLEAR_CODE, 1'b0); // release byte that wipes the keymap
        send_query(7'd0);
    endtask

    // Control, alt and the toggle key at random and at the ends of the map.
    task automatic test_modifier_overlay();
        logic [CODE_W-1:0] c;
        logic [CODE_W-1:0] a;
        c = CODE_W'($urandom_range(0, KEYS - 1));
        a = CODE_W'($urandom_range(0, KEYS - 1));
        program_registers(GAP_W'($urandom_range(200, 5000)), c, a,
                          CODE_W'($urandom_range(0, KEYS - 1)));
        random_traffic(300, 40);
        program_registers(16'd3000, 7'd0, 7'(KEYS - 1), 7'd0);
        random_traffic(150, 40);
    endtask

    // Silence limits of one and of the largest value.
    task automatic test_gap_limits();
        program_registers(16'd1, cfg_ctrl, cfg_alt, 7'(KEYS - 1));
        random_traffic(200, 40);
        program_registers(16'hFFFF, CTRL_CODE_RST, ALT_CODE_RST, TOGGLE_CODE_RST);
        random_traffic(200, 40);
    endtask

    // Modifier registers naming codes past the keymap never count as held.
    task automatic test_unmapped_modifiers();
        program_registers(16'd800, 7'd127, 7'(KEYS), 7'($urandom_range(0, 127)));
        random_traffic(150, 40);
    endtask

    // Long random run; the last stretch keeps the line busy with no idling.
    task automatic test_mixed_traffic();
        program_registers(GAP_LIMIT_RST, CTRL_CODE_RST, ALT_CODE_RST, TOGGLE_CODE_RST);
        random_traffic(300, 60);
        random_traffic(200, 0);
    endtask

    // Every result beat is checked against the oldest owed result.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                flag_mismatch("result beat with nothing owed", 32'(key_byte), 0);
            end
            else
            begin
                head = awaited_results.pop_front();
                if (byte_valid !== head.byte_valid)
                    flag_mismatch("byte_valid", 32'(byte_valid), 32'(head.byte_valid));
                if (key_byte !== head.key_byte)
                    flag_mismatch("key_byte", 32'(key_byte), 32'(head.key_byte));
                if (ack_request !== head.ack)
                    flag_mismatch("ack_request", 32'(ack_request), 32'(head.ack));
                if (force_release !== head.force_rel)
                    flag_mismatch("force_release", 32'(force_release), 32'(head.force_rel));
                if (pressed !== head.pressed)
                    flag_mismatch("pressed", 32'(pressed), 32'(head.pressed));
                if (overlay_held_out !== head.overlay)
                    flag_mismatch("overlay_held_out", 32'(overlay_held_out),
                                  32'(head.overlay));
            end
        end
    end

    initial
    begin
        int spin;
        foreach (key_map[i])
            key_map[i] = 2'b00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_modifier_overlay();
        test_gap_limits();
        test_unmapped_modifiers();
        test_mixed_traffic();

        start <= 1'b0;
        for (spin = 0; spin < 200 && awaited_results.size() != 0; spin++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (awaited_results.size() != 0)
            flag_mismatch("results never delivered", awaited_results.size(), 0);

        $display("Sent %0d items (%0d queries) under %0d register settings.",
                 items_sent, queries_sent, settings_used);
        $display("Decoded %0d key bytes, dropped %0d edges, flipped overlay hold %0d times.",
                 bytes_decoded, edges_dropped, overlay_flips);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
